@@ sv/fdl_pkg.sv @@
// Shared types and constants of the feedback delay lowpass block.
`default_nettype none

package fdl_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 17;
  localparam int LEN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [MIX_W-1:0]  Q16_ONE          = 17'h10000;
  localparam logic [GAIN_W-1:0] ALPHA_WARM       = 16'd10486;
  localparam logic [GAIN_W-1:0] ALPHA_BRIGHT     = 16'd26870;
  localparam logic [LEN_W-1:0]  DELAY_LENGTH_RST = 16'd882;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH,
    REG_FEEDBACK_GAIN,
    REG_MIX_GAIN,
    REG_WARM_MODE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILT,
    ST_WRITE
  } fdl_state_t;

endpackage

`default_nettype wire

@@ sv/fdl_in_if.sv @@
// Input sample channel: dry sample and end-of-clip mark.
`default_nettype none

interface fdl_in_if import fdl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t audio_in;
  logic    end_of_clip;

  modport source (output valid, output audio_in, output end_of_clip, input ready);
  modport sink   (input valid, input audio_in, input end_of_clip, output ready);
endinterface

`default_nettype wire

@@ sv/fdl_out_if.sv @@
// Result channel: mixed sample and feedback clip flag.
`default_nettype none

interface fdl_out_if import fdl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t audio_out;
  logic    feedback_clipped;

  modport source (output valid, output audio_out, output feedback_clipped, input ready);
  modport sink   (input valid, input audio_out, input feedback_clipped, output ready);
endinterface

`default_nettype wire

@@ sv/fdl_cfg_if.sv @@
// Register write channel: register index and write data.
`default_nettype none

interface fdl_cfg_if import fdl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/feedback_delay_lowpass.sv @@
// Feedback delay line with a one-pole lowpass in the loop; top level.
//
// Per sample, the accept beat issues the delay memory read, then come the
// mix/lowpass multiplies, the feedback multiply and the saturating writeback
// into the same entry; with the single-port read-modify-write, a new sample
// is accepted only after that writeback. A finished result waits in an output
// register, so the next sample is accepted while it is still pending. The
// delay memory has no clearing pass: a fill count marks the entries written
// since reset or since the last end-of-clip beat, and entries at or above it
// read as zero, so the block is ready right after reset and an end-of-clip
// beat needs no clearing step. Register writes are always accepted.
`default_nettype none

module feedback_delay_lowpass import fdl_pkg::*; #(
  parameter int MAX_DELAY = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  fdl_in_if.sink    in_bus,
  fdl_out_if.source out_bus,
  fdl_cfg_if.sink   cfg_bus
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DELAY);

  logic [LEN_W-1:0]  delay_length_r;
  logic [GAIN_W-1:0] feedback_gain_r;
  logic [MIX_W-1:0]  mix_gain_r;
  logic              warm_mode_r;

  fdl_state_t state_r, state_nxt;

  logic [AW-1:0] pos_r;
  logic [LW-1:0] fill_r;
  sample_t       lp_r;
  logic          out_valid_r;

  sample_t       dry_r;
  logic          eoc_r;
  logic [AW-1:0] addr_r;
  logic          hit_r;
  sample_t       rdata_r;
  sample_t       wet_r;
  sample_t       fbr_r;
  sample_t       out_audio_r;
  logic          out_clip_r;

  sample_t mem [MAX_DELAY];

  logic              in_acc;
  logic              out_acc;
  logic              write_go;
  logic [LW-1:0]     len_eff;
  logic [AW-1:0]     pos_start;
  logic [LW-1:0]     pos_inc;
  logic [MIX_W-1:0]  mix_eff;
  logic [GAIN_W-1:0] alpha;
  sample_t           del;
  logic signed [24:0] diff_w;
  logic signed [42:0] prod_w;
  logic signed [42:0] sum_w;
  logic signed [24:0] diff_l;
  logic signed [41:0] prod_l;
  logic signed [41:0] sum_l;
  logic signed [40:0] prod_f;
  logic signed [40:0] sum_f;
  logic signed [24:0] acc;
  logic              clip;
  sample_t           wdata;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_length_r  <= DELAY_LENGTH_RST;
      feedback_gain_r <= '0;
      mix_gain_r      <= '0;
      warm_mode_r     <= 1'b0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.index))
        REG_DELAY_LENGTH:  delay_length_r  <= cfg_bus.data[LEN_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_bus.data[GAIN_W-1:0];
        REG_MIX_GAIN:      mix_gain_r      <= cfg_bus.data[MIX_W-1:0];
        REG_WARM_MODE:     warm_mode_r     <= cfg_bus.data[0];
      endcase
    end
  end

  // state machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_bus.valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_FILT;
      ST_FILT:  state_nxt = ST_WRITE;
      ST_WRITE: if (!out_valid_r || out_bus.ready) state_nxt = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_bus.ready = 1'b0;
    write_go     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_bus.ready = 1'b1;
      ST_READ:  ;
      ST_FILT:  ;
      ST_WRITE: write_go = !out_valid_r || out_bus.ready;
    endcase
  end

  assign in_acc  = in_bus.valid && in_bus.ready;
  assign out_acc = out_valid_r && out_bus.ready;

  // position and length
  always_comb begin
    if (delay_length_r == '0) begin
      len_eff = LW'(1);
    end else if (LW'(delay_length_r) > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LW'(delay_length_r);
    end
    pos_start = (LW'(pos_r) >= len_eff) ? '0 : pos_r;
    pos_inc   = LW'(addr_r) + LW'(1);
  end

  // datapath arithmetic, products rounded half up
  always_comb begin
    del     = hit_r ? rdata_r : '0;
    mix_eff = (mix_gain_r > Q16_ONE) ? Q16_ONE : mix_gain_r;
    alpha   = warm_mode_r ? ALPHA_WARM : ALPHA_BRIGHT;

    diff_w = {del[23], del} - {dry_r[23], dry_r};
    prod_w = $signed({1'b0, mix_eff}) * diff_w;
    sum_w  = prod_w + $signed({{3{dry_r[23]}}, dry_r, 16'd0}) + 43'sd32768;

    diff_l = {lp_r[23], lp_r} - {del[23], del};
    prod_l = $signed({1'b0, alpha}) * diff_l;
    sum_l  = prod_l + $signed({{2{del[23]}}, del, 16'd0}) + 42'sd32768;

    prod_f = $signed({1'b0, feedback_gain_r}) * lp_r;
    sum_f  = prod_f + 41'sd32768;

    acc  = {fbr_r[23], fbr_r} + {dry_r[23], dry_r};
    clip = acc[24] ^ acc[23];
    if (clip) begin
      wdata = acc[24] ? sample_t'(24'h800000) : sample_t'(24'h7FFFFF);
    end else begin
      wdata = acc[23:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      lp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_READ) begin
        lp_r <= sum_l[39:16];
      end
      if (write_go) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (write_go) begin
        if (eoc_r) begin
          pos_r  <= '0;
          fill_r <= '0;
          lp_r   <= '0;
        end else begin
          pos_r <= (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
          if (LW'(addr_r) == fill_r) begin
            fill_r <= fill_r + LW'(1);
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r  <= in_bus.audio_in;
      eoc_r  <= in_bus.end_of_clip;
      addr_r <= pos_start;
      hit_r  <= LW'(pos_start) < fill_r;
    end
    if (state_r == ST_READ) begin
      wet_r <= sum_w[39:16];
    end
    if (state_r == ST_FILT) begin
      fbr_r <= sum_f[39:16];
    end
    if (write_go) begin
      out_audio_r <= wet_r;
      out_clip_r  <= clip;
    end
  end

  // delay memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdata_r <= mem[pos_start];
    end
    if (write_go) begin
      mem[addr_r] <= wdata;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.audio_out        = out_audio_r;
  assign out_bus.feedback_clipped = out_clip_r;

endmodule

`default_nettype wire

@@ sv/fdl_checker.sv @@
// Port-level checker for the feedback delay lowpass block, with its bind.
`default_nettype none

module fdl_checker import fdl_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_audio,
  input logic    out_clip
);

  logic [1:0] cnt_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // samples accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_audio) && $stable(out_clip))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("sample accepted while previous one in flight");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 2'd0)
    else $error("result beat without an accepted sample");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("more than two samples outstanding");

endmodule

bind feedback_delay_lowpass fdl_checker u_fdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_audio (out_bus.audio_out),
  .out_clip  (out_bus.feedback_clipped)
);

`default_nettype wire

@@ dv/fdl_echo_checker.sv @@
// Checker for the echo block: predicts each mixed sample and compares result beats.
`timescale 1ns / 1ps

module fdl_echo_checker import fdl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fdl_in_if    in_bus,
  fdl_out_if   out_bus,
  fdl_cfg_if   cfg_bus,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    sample_t audio;
    logic    clip;
  } echo_result_t;

  echo_result_t      mix_q[$];
  echo_result_t      want;
  sample_t           dly_mem[int unsigned];  // absent entry reads as zero
  logic [LEN_W-1:0]  wr_pos;
  sample_t           lp_state;
  logic [LEN_W-1:0]  len_reg;
  logic [GAIN_W-1:0] fb_reg;
  logic [MIX_W-1:0]  mix_reg;
  logic              warm_reg;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // round to nearest Q16 step, ties up
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic void predict_echo(input sample_t dry, input logic eoc);
    int unsigned  len;
    int unsigned  pos;
    longint       mix;
    longint       alpha;
    longint       acc;
    longint       wet;
    longint       lp;
    sample_t      delayed;
    echo_result_t res;
    len     = (len_reg == '0) ? 32'd1 : 32'(len_reg);
    pos     = 32'(wr_pos);
    if (pos >= len) pos = 0;
    mix     = (mix_reg > Q16_ONE) ? 65536 : longint'(mix_reg);
    alpha   = warm_reg ? longint'(ALPHA_WARM) : longint'(ALPHA_BRIGHT);
    delayed = dly_mem.exists(pos) ? dly_mem[pos] : '0;
    wet     = round_q16((65536 - mix) * longint'(dry) + mix * longint'(delayed));
    lp      = round_q16((65536 - alpha) * longint'(delayed) + alpha * longint'(lp_state));
    lp_state = lp[SAMPLE_W-1:0];
    acc     = longint'(dry) + round_q16(longint'(fb_reg) * longint'(lp_state));
    res.clip = 1'b0;
    if (acc > 64'sd8388607) begin
      acc = 64'sd8388607;
      res.clip = 1'b1;
    end
    if (acc < -64'sd8388608) begin
      acc = -64'sd8388608;
      res.clip = 1'b1;
    end
    dly_mem[pos] = acc[SAMPLE_W-1:0];
    pos++;
    if (pos >= len) pos = 0;
    wr_pos = pos[LEN_W-1:0];
    res.audio = wet[SAMPLE_W-1:0];
    mix_q.push_back(res);
    if (eoc) begin
      dly_mem.delete();
      lp_state = '0;
      wr_pos   = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mix_q.delete();
      dly_mem.delete();
      wr_pos   = '0;
      lp_state = '0;
      len_reg  = DELAY_LENGTH_RST;
      fb_reg   = '0;
      mix_reg  = '0;
      warm_reg = 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_DELAY_LENGTH:  len_reg  = cfg_bus.data[LEN_W-1:0];
          REG_FEEDBACK_GAIN: fb_reg   = cfg_bus.data[GAIN_W-1:0];
          REG_MIX_GAIN:      mix_reg  = cfg_bus.data[MIX_W-1:0];
          REG_WARM_MODE:     warm_reg = cfg_bus.data[0];
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        if (mix_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d/%0b with nothing pending",
                                    out_bus.audio_out, out_bus.feedback_clipped));
        end else begin
          want = mix_q.pop_front();
          if (out_bus.audio_out !== want.audio)
            report_mismatch($sformatf("audio_out %0d, predicted %0d",
                                      out_bus.audio_out, want.audio));
          if (out_bus.feedback_clipped !== want.clip)
            report_mismatch($sformatf("feedback_clipped %0b, predicted %0b",
                                      out_bus.feedback_clipped, want.clip));
        end
      end
      if (in_bus.valid && in_bus.ready)
        predict_echo(in_bus.audio_in, in_bus.end_of_clip);
    end
    outstanding = mix_q.size();
  end

endmodule

@@ dv/feedback_delay_lowpass_test.sv @@
// Testbench top for the echo block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module feedback_delay_lowpass_test import fdl_pkg::*;;

  localparam sample_t S_MAX = sample_t'(24'h7FFFFF);
  localparam sample_t S_MIN = sample_t'(24'h800000);

  logic clk = 1'b0;
  logic rst_n;
  logic steady;
  int   mismatches;
  int   outstanding;

  fdl_in_if  in_bus();
  fdl_out_if out_bus();
  fdl_cfg_if cfg_bus();

  feedback_delay_lowpass dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  fdl_echo_checker echo_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_bus     (cfg_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result-side backpressure: long open stretches, short and long stalls
  initial begin : result_stall
    int   n;
    logic lvl;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      case ($urandom_range(0, 9))
        0, 1: begin
          lvl = 1'b1;
          n   = $urandom_range(20, 80);
        end
        2: begin
          lvl = 1'b0;
          n   = $urandom_range(8, 40);
        end
        3, 4, 5: begin
          lvl = 1'b0;
          n   = $urandom_range(1, 3);
        end
        default: begin
          lvl = 1'b1;
          n   = $urandom_range(1, 4);
        end
      endcase
      out_bus.ready <= lvl;
      repeat (n - 1) @(negedge clk);
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.index <= r;
    cfg_bus.data  <= d;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // drain, let the last writeback land, then write the selected registers
  task automatic apply_setup(input logic [3:0] pick, input logic [LEN_W-1:0] len,
                             input logic [GAIN_W-1:0] fb, input logic [MIX_W-1:0] mix,
                             input logic warm);
    in_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (pick[REG_DELAY_LENGTH])  write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(len));
    if (pick[REG_FEEDBACK_GAIN]) write_reg(REG_FEEDBACK_GAIN, CFG_DATA_W'(fb));
    if (pick[REG_MIX_GAIN])      write_reg(REG_MIX_GAIN, CFG_DATA_W'(mix));
    if (pick[REG_WARM_MODE])     write_reg(REG_WARM_MODE, CFG_DATA_W'(warm));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_sample(input sample_t s, input logic eoc);
    int gap;
    gap = 0;
    if (!steady) begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(6, 30);
        1, 2, 3: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.audio_in    <= s;
    in_bus.end_of_clip <= eoc;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int               r;
    sample_t          s;
    logic [LEN_W-1:0] len;
    logic [GAIN_W-1:0] fb;
    logic [MIX_W-1:0] mix;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.audio_in    <= '0;
    in_bus.end_of_clip <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_DELAY_LENGTH;
    cfg_bus.data       <= '0;
    steady = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // zero length acts as one, mix above range, maximum feedback, saturation both ways
    apply_setup(4'hF, 16'd0, 16'hFFFF, 17'h1FFFF, 1'b1);
    repeat (3) send_sample(S_MAX, 1'b0);
    repeat (3) send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);

    // half mix, feedback of about 0.95, then shrink length below the write position
    apply_setup(4'hF, 16'd6, 16'd62259, 17'd32768, 1'b0);
    for (int i = 0; i < 10; i++)
      send_sample((i % 3 == 2) ? sample_t'(24'h12D687) : (i[0] ? S_MIN : S_MAX), 1'b0);
    apply_setup(4'b0001, 16'd3, '0, '0, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(sample_t'(24'd4096), 1'b1);
    send_sample(sample_t'(-24'sd4096), 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      r = $urandom_range(0, 99);
      if (r < 10)      len = 16'd0;
      else if (r < 18) len = 16'hFFFF;
      else if (r < 23) len = DELAY_LENGTH_RST;
      else if (r < 90) len = LEN_W'($urandom_range(1, 40));
      else             len = LEN_W'($urandom_range(41, 300));
      if (ph == 4) len = 16'hFFFF;
      r = $urandom_range(0, 99);
      if (r < 20)      fb = '0;
      else if (r < 45) fb = 16'd62259;
      else if (r < 55) fb = 16'hFFFF;
      else             fb = GAIN_W'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 20)      mix = '0;
      else if (r < 40) mix = Q16_ONE;
      else if (r < 48) mix = 17'h1FFFF;
      else             mix = MIX_W'($urandom_range(0, 65536));
      apply_setup(4'($urandom_range(1, 15)), len, fb, mix, 1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 65; i++) begin
        if (ph == 0 && i == 30) begin
          // sender holds off until every pending result is out
          in_bus.valid <= 1'b0;
          while (outstanding != 0) @(negedge clk);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
          case ($urandom_range(0, 3))
            0:       s = S_MAX;
            1:       s = S_MIN;
            2:       s = '0;
            default: s = '1;
          endcase
        end else if (r < 40) begin
          s = sample_t'(int'($urandom_range(0, 8191)) - 4096);
        end else begin
          s = sample_t'($urandom);
        end
        send_sample(s, $urandom_range(0, 49) == 0);
      end
    end

    in_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
